FILE: rtl/fa2_pkg.sv
// package: payload types and constants for the atan2 unit
`default_nettype none
package fa2_pkg;
    localparam int IN_WIDTH_DEF    = 16;
    localparam int ANGLE_FRAC_DEF  = 13;
    localparam int ANGLE_WIDTH_DEF = ANGLE_FRAC_DEF + 3;

    // polynomial coefficients, unsigned Q.30
    localparam logic [31:0] C_PI4     = 32'd843314857;
    localparam logic [31:0] C_A       = 32'd262744624;
    localparam logic [31:0] C_B       = 32'd71189083;
    localparam logic [31:0] C_HALF_PI = 32'd1686629713;
    localparam int          Q_BITS    = 15;

    // quadrant codes
    localparam logic [1:0] QC_0 = 2'd0;
    localparam logic [1:0] QC_1 = 2'd1;
    localparam logic [1:0] QC_2 = 2'd2;
    localparam logic [1:0] QC_3 = 2'd3;

    typedef struct packed {
        logic signed [IN_WIDTH_DEF-1:0] y_in;
        logic signed [IN_WIDTH_DEF-1:0] x_in;
    } t_in_item;

    typedef struct packed {
        logic signed [ANGLE_WIDTH_DEF-1:0] angle;
        logic                              both_zero;
    } t_out_item;

    // control that travels with each item through the chain
    typedef struct packed {
        logic       vld;
        logic       zero;
        logic       swap;
        logic       neg;
        logic [1:0] qc;
    } t_ctl;
endpackage
`default_nettype wire

FILE: rtl/fa2_div_cell.sv
// divider cell: one restoring quotient bit per stage, passed to the next cell
`default_nettype none
module fa2_div_cell
    import fa2_pkg::*;
#(
    parameter int MAG_W = 17,
    parameter int NUM_W = 34
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire t_ctl             i_ctl,
    input  wire logic [NUM_W-1:0] i_rem,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [MAG_W:0]   i_den,
    input  wire logic [17:0]      i_quo,
    output t_ctl                  o_ctl,
    output logic [NUM_W-1:0]      o_rem,
    output logic [NUM_W-1:0]      o_num,
    output logic [MAG_W:0]        o_den,
    output logic [17:0]           o_quo
);
    logic [NUM_W:0]   w_try;
    logic [NUM_W:0]   w_sub;
    logic             w_bit;

    // shift in next numerator bit and trial subtract
    assign w_try = {i_rem, i_num[NUM_W-1]};
    assign w_sub = w_try - {{(NUM_W-MAG_W){1'b0}}, i_den};
    assign w_bit = ~w_sub[NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_adv) begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_rem <= w_bit ? w_sub[NUM_W-1:0] : w_try[NUM_W-1:0];
            o_num <= {i_num[NUM_W-2:0], 1'b0};
            o_den <= i_den;
            o_quo <= {i_quo[16:0], w_bit};
        end
    end
endmodule
`default_nettype wire

FILE: rtl/fa2_poly.sv
// polynomial and octant fold, pipelined
`default_nettype none
module fa2_poly
    import fa2_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_adv,
    input  wire t_ctl       i_ctl,
    input  wire logic [16:0] i_m,
    output t_ctl            o_ctl,
    output logic signed [ANGLE_WIDTH_DEF-1:0] o_angle
);
    localparam int SH = 30 - ANGLE_FRAC_DEF;
    localparam int AW = ANGLE_WIDTH_DEF;

    t_ctl         r_c1, r_c2, r_c3, r_c4;
    logic [31:0]  r_t1;
    logic [31:0]  r_p1;
    logic [31:0]  r_u1;
    logic [31:0]  r_t2, r_u2, r_p2;
    logic [31:0]  r_v3, r_p3;
    logic signed [33:0] r_z4;

    logic [48:0]  w_bm;
    logic [48:0]  w_pm;
    logic [33:0]  w_u;
    logic [63:0]  w_ut;
    logic signed [33:0] w_z, w_zf, w_mag;
    logic [33:0]  w_r;
    logic signed [33:0] w_hp;

    assign w_bm = C_B * i_m;
    assign w_pm = C_PI4 * i_m;
    assign w_u  = {17'd0, i_m} * {17'd0, (17'd32768 - i_m)};
    assign w_ut = r_u2 * r_t2;
    assign w_hp = $signed({2'b00, C_HALF_PI});

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_t1 <= C_A + w_bm[46:15];
            r_p1 <= w_pm[46:15];
            r_u1 <= w_u[31:0];
            r_t2 <= r_t1;
            r_u2 <= r_u1;
            r_p2 <= r_p1;
            r_v3 <= w_ut[61:30];
            r_p3 <= r_p2;
            r_z4 <= w_zf;
        end
    end

    always_comb begin
        w_z = $signed({2'b00, r_p3 + r_v3});
        if (r_c3.neg) w_z = -w_z;
        w_zf = w_z;
        if (r_c3.swap) begin
            w_zf = (r_c3.qc == QC_0 || r_c3.qc == QC_1) ? (w_hp - w_z) : (-w_hp - w_z);
        end else if (r_c3.qc == QC_1) begin
            w_zf = 34'sd2 * w_hp + w_z;
        end else if (r_c3.qc == QC_2) begin
            w_zf = -(34'sd2 * w_hp) + w_z;
        end
        if (r_c3.zero) w_zf = '0;
    end

    // round half away from zero
    assign w_mag = r_z4[33] ? -r_z4 : r_z4;
    assign w_r   = ($unsigned(w_mag) + (34'd1 << (SH - 1))) >> SH;
    assign o_angle = r_z4[33] ? -$signed(w_r[AW-1:0]) : $signed(w_r[AW-1:0]);
    assign o_ctl   = r_c4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0; r_c2 <= '0; r_c3 <= '0; r_c4 <= '0;
        end else if (i_adv) begin
            r_c1 <= i_ctl; r_c2 <= r_c1; r_c3 <= r_c2; r_c4 <= r_c3;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/fast_atan2_approximation_unit.sv
// top level: pipelined fixed-point atan2 with a chain of divider cells
`default_nettype none
//  channel | direction | payload    | handshake
//  in      | input     | t_in_item  | i_in_valid / o_in_stall
//  out     | output    | t_out_item | o_out_valid / i_out_stall
//  one transaction per cycle sustained unless a valid result is stalled at the output
//  the divider chain has 17 cells, one quotient bit per cell
//  the whole pipe advances together; an output stall on a valid result freezes every stage
//  input stall is raised only while a valid result is stalled, so no transaction is lost in a full pipe
//  synchronous active-low reset clears all valid bits
module fast_atan2_approximation_unit
    import fa2_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);
    localparam int MAG_W = IN_WIDTH_DEF + 1;          // magnitude incl. most negative
    localparam int NUM_W = 2 * MAG_W;                 // small*2^16 + large
    localparam int NCELL = 17;                        // quotient bits 0..32768

    logic w_adv;
    // pipe advances unless a finished result is being held
    assign w_adv      = ~(o_out_valid & i_out_stall);
    assign o_in_stall = ~w_adv;

    // front stage: magnitudes, swap, quadrant code
    logic [MAG_W-1:0] w_ay, w_ax, w_sm, w_lg;
    t_ctl             w_ctl;
    logic signed [IN_WIDTH_DEF-1:0] w_y, w_x;

    assign w_y  = i_in_data.y_in;
    assign w_x  = i_in_data.x_in;
    assign w_ay = w_y[IN_WIDTH_DEF-1] ? -{w_y[IN_WIDTH_DEF-1], w_y} : {1'b0, w_y};
    assign w_ax = w_x[IN_WIDTH_DEF-1] ? -{w_x[IN_WIDTH_DEF-1], w_x} : {1'b0, w_x};

    always_comb begin
        w_ctl.vld  = i_in_valid;
        w_ctl.zero = (w_ay == '0) && (w_ax == '0);
        w_ctl.swap = w_ay > w_ax;
        w_ctl.neg  = w_x[IN_WIDTH_DEF-1] != w_y[IN_WIDTH_DEF-1];
        // earlier tests take priority, so the tie at zero resolves downwards
        priority if (!w_x[IN_WIDTH_DEF-1] && (w_y[IN_WIDTH_DEF-1] || w_y == '0))
            w_ctl.qc = QC_3;
        else if ((w_x[IN_WIDTH_DEF-1] || w_x == '0) && (w_y[IN_WIDTH_DEF-1] || w_y == '0))
            w_ctl.qc = QC_2;
        else if (w_x[IN_WIDTH_DEF-1] || w_x == '0)
            w_ctl.qc = QC_1;
        else
            w_ctl.qc = QC_0;
    end
    assign w_sm = w_ctl.swap ? w_ax : w_ay;
    assign w_lg = w_ctl.swap ? w_ay : w_ax;

    t_ctl              r_ctl;
    logic [NUM_W-1:0]  r_num;
    logic [MAG_W:0]    r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (w_adv) begin
            r_ctl <= w_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // numerator (small<<16)+large; zero denominator guarded by both_zero
            r_num <= ({{(NUM_W-MAG_W){1'b0}}, w_sm} << 16) + {{(NUM_W-MAG_W){1'b0}}, w_lg};
            r_den <= {w_lg, 1'b0};
        end
    end

    // chain of divider cells
    t_ctl             c_ctl [NCELL+1];
    logic [NUM_W-1:0] c_rem [NCELL+1];
    logic [NUM_W-1:0] c_num [NCELL+1];
    logic [MAG_W:0]   c_den [NCELL+1];
    logic [17:0]      c_quo [NCELL+1];

    // the top NUM_W-NCELL numerator bits seed the remainder
    assign c_ctl[0] = r_ctl;
    assign c_rem[0] = {{NCELL{1'b0}}, r_num[NUM_W-1:NCELL]};
    assign c_num[0] = {r_num[NCELL-1:0], {(NUM_W-NCELL){1'b0}}};
    assign c_den[0] = r_den;
    assign c_quo[0] = '0;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        fa2_div_cell #(.MAG_W(MAG_W), .NUM_W(NUM_W)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (w_adv),
            .i_ctl  (c_ctl[g]),
            .i_rem  (c_rem[g]),
            .i_num  (c_num[g]),
            .i_den  (c_den[g]),
            .i_quo  (c_quo[g]),
            .o_ctl  (c_ctl[g+1]),
            .o_rem  (c_rem[g+1]),
            .o_num  (c_num[g+1]),
            .o_den  (c_den[g+1]),
            .o_quo  (c_quo[g+1])
        );
    end

    // polynomial and fold
    t_ctl w_pctl;
    logic signed [ANGLE_WIDTH_DEF-1:0] w_angle;

    fa2_poly u_poly (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (w_adv),
        .i_ctl  (c_ctl[NCELL]),
        .i_m    (c_quo[NCELL][16:0]),
        .o_ctl  (w_pctl),
        .o_angle(w_angle)
    );

    assign o_out_valid          = w_pctl.vld;
    assign o_out_data.angle     = w_angle;
    assign o_out_data.both_zero = w_pctl.zero;

    logic w_unused;
    assign w_unused = ^{c_quo[NCELL][17], c_rem[NCELL], c_num[NCELL], c_den[NCELL]};
endmodule
`default_nettype wire

FILE: rtl/fa2_checker.sv
// checker: port-level properties of the atan2 unit, bound to the top level
`default_nettype none
module fa2_checker
    import fa2_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data
);
    // a zero-vector flag always comes with a zero angle
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.both_zero) |-> (o_out_data.angle == '0))
        else $error("both_zero with nonzero angle");

    // angle stays within plus or minus pi
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_out_data.angle) <= 16'sd25736 &&
                         $signed(o_out_data.angle) >= -16'sd25736))
        else $error("angle out of range");

    // input is held off exactly while a result is stalled
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall not tied to output stall");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");
endmodule

bind fast_atan2_approximation_unit fa2_checker u_fa2_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);
`default_nettype wire
